// ----- rtl/lfs_pkg.sv -----
// Shared types, codes and tables for the line-follow steering core.
// The steering pattern table and the speed clamp live here; no dependencies.
package lfs_pkg;

	localparam int SpdW = 8;
	localparam int RawW = 10;
	localparam int CntW = 6;

	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_FWD    = 2'd1;
	localparam logic [1:0] CMD_REV    = 2'd2;
	localparam logic [1:0] CMD_CANCEL = 2'd3;

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_FWD  = 2'd1;
	localparam logic [1:0] MODE_REV  = 2'd2;

	localparam logic [1:0] MEMO_NONE  = 2'd0;
	localparam logic [1:0] MEMO_RIGHT = 2'd1;
	localparam logic [1:0] MEMO_LEFT  = 2'd2;

	// correction families: right family is blocked by a left memo and vice versa
	localparam logic [1:0] FAM_CENTER = 2'd0;
	localparam logic [1:0] FAM_RIGHT  = 2'd1;
	localparam logic [1:0] FAM_LEFT   = 2'd2;

	localparam logic REG_LEFT_BASE  = 1'b0;
	localparam logic REG_RIGHT_BASE = 1'b1;

	localparam logic [CntW-1:0] FWD_BLANK_LIMIT = 6'd10;
	localparam logic [CntW-1:0] REV_BLANK_LIMIT = 6'd60;

	localparam logic [7:0] PAT_ALL_BLACK = 8'h00;
	localparam logic [7:0] PAT_ALL_WHITE = 8'hFF;

	localparam logic signed [RawW-1:0] SPD_MAX = 10'sd100;
	localparam logic signed [RawW-1:0] SPD_MIN = 10'sd5;

	typedef struct packed {
		logic                   hit;
		logic [1:0]             fam;
		logic [1:0]             memo;
		logic                   memo_wr;
		logic signed [RawW-1:0] l;
		logic signed [RawW-1:0] r;
	} steer_ent_t;

	typedef struct packed {
		logic                   take;
		logic                   memo_wr;
		logic [1:0]             memo;
		logic signed [RawW-1:0] l;
		logic signed [RawW-1:0] r;
	} steer_upd_t;

	typedef struct packed {
		logic signed [SpdW-1:0] left;
		logic signed [SpdW-1:0] right;
		logic                   mval;
		logic                   done;
		logic                   card;
		logic [1:0]             mode;
	} res_t;

	function automatic steer_ent_t mk_ent(input logic [1:0] fam, input logic [1:0] memo,
			input logic memo_wr, input logic signed [RawW-1:0] l,
			input logic signed [RawW-1:0] r);
		steer_ent_t e;
		e.hit     = 1'b1;
		e.fam     = fam;
		e.memo    = memo;
		e.memo_wr = memo_wr;
		e.l       = l;
		e.r       = r;
		return e;
	endfunction

	// forward: absolute speeds; reverse: offsets added to the base registers
	function automatic steer_ent_t steer_lookup(input logic [7:0] g, input logic fwd);
		steer_ent_t e;
		e = '0;
		unique case (g)
			8'hE7: e = fwd ? mk_ent(FAM_CENTER, MEMO_NONE, 1'b0, 10'sd70, 10'sd95)
			               : mk_ent(FAM_CENTER, MEMO_NONE, 1'b0, 10'sd0, 10'sd0);
			8'hF7: e = fwd ? mk_ent(FAM_RIGHT, MEMO_NONE, 1'b1, 10'sd95, -10'sd30)
			               : mk_ent(FAM_RIGHT, MEMO_NONE, 1'b1, 10'sd0, 10'sd0);
			8'hF3, 8'hFB, 8'hF1:
				e = fwd ? mk_ent(FAM_RIGHT, MEMO_NONE, 1'b1, 10'sd95, -10'sd70)
				        : mk_ent(FAM_RIGHT, MEMO_NONE, 1'b1, 10'sd155, -10'sd5);
			8'hF9, 8'hFD, 8'hF8:
				e = fwd ? mk_ent(FAM_RIGHT, MEMO_NONE, 1'b1, 10'sd90, -10'sd80)
				        : mk_ent(FAM_RIGHT, MEMO_NONE, 1'b1, 10'sd160, -10'sd10);
			8'hFC: e = fwd ? mk_ent(FAM_RIGHT, MEMO_NONE, 1'b1, 10'sd90, -10'sd90)
			               : mk_ent(FAM_RIGHT, MEMO_NONE, 1'b1, 10'sd165, -10'sd15);
			8'hFE: e = fwd ? mk_ent(FAM_RIGHT, MEMO_RIGHT, 1'b1, 10'sd95, -10'sd100)
			               : mk_ent(FAM_RIGHT, MEMO_RIGHT, 1'b1, 10'sd170, -10'sd20);
			8'hEF: e = fwd ? mk_ent(FAM_LEFT, MEMO_NONE, 1'b1, -10'sd20, 10'sd100)
			               : mk_ent(FAM_LEFT, MEMO_NONE, 1'b1, 10'sd0, 10'sd0);
			8'hCF, 8'hDF, 8'h8F:
				e = fwd ? mk_ent(FAM_LEFT, MEMO_NONE, 1'b1, -10'sd70, 10'sd95)
				        : mk_ent(FAM_LEFT, MEMO_NONE, 1'b1, 10'sd0, 10'sd140);
			8'h9F, 8'h1F:
				e = fwd ? mk_ent(FAM_LEFT, MEMO_NONE, 1'b1, -10'sd80, 10'sd95)
				        : mk_ent(FAM_LEFT, MEMO_NONE, 1'b1, -10'sd5, 10'sd145);
			8'hBF: e = fwd ? mk_ent(FAM_LEFT, MEMO_NONE, 1'b1, -10'sd80, 10'sd95)
			               : mk_ent(FAM_LEFT, MEMO_NONE, 1'b1, -10'sd10, 10'sd150);
			8'h3F: e = fwd ? mk_ent(FAM_LEFT, MEMO_NONE, 1'b1, -10'sd90, 10'sd95)
			               : mk_ent(FAM_LEFT, MEMO_NONE, 1'b1, -10'sd10, 10'sd150);
			8'h7F: e = fwd ? mk_ent(FAM_LEFT, MEMO_LEFT, 1'b1, -10'sd100, 10'sd95)
			               : mk_ent(FAM_LEFT, MEMO_LEFT, 1'b1, -10'sd15, 10'sd155);
			default: e = '0;
		endcase
		return e;
	endfunction

	function automatic logic signed [SpdW-1:0] clamp_speed(input logic signed [RawW-1:0] s);
		logic signed [RawW-1:0] c;
		c = s;
		if (s >= 0) begin
			if (s > SPD_MAX)
				c = SPD_MAX;
			else if (s < SPD_MIN)
				c = SPD_MIN;
		end else begin
			if (s < -SPD_MAX)
				c = -SPD_MAX;
			else if (s > -SPD_MIN)
				c = -SPD_MIN;
		end
		return c[SpdW-1:0];
	endfunction

endpackage

// ----- rtl/lfs_steer.sv -----
// Steering table lookup with edge-memo blocking and reverse base offsets.
// Depends on lfs_pkg.
module lfs_steer import lfs_pkg::*; (
	input  logic [7:0]             g,
	input  logic                   fwd,
	input  logic [1:0]             memo,
	input  logic signed [SpdW-1:0] lbase,
	input  logic signed [SpdW-1:0] rbase,
	output steer_upd_t             upd
);

	steer_ent_t             ent;
	logic                   allow;
	logic signed [RawW-1:0] lb_ext;
	logic signed [RawW-1:0] rb_ext;

	assign ent    = steer_lookup(g, fwd);
	assign lb_ext = RawW'(lbase);
	assign rb_ext = RawW'(rbase);

	assign allow = (ent.fam == FAM_CENTER) ||
	               ((ent.fam == FAM_RIGHT) && (memo != MEMO_LEFT)) ||
	               ((ent.fam == FAM_LEFT) && (memo != MEMO_RIGHT));

	assign upd.take    = ent.hit && allow;
	assign upd.memo_wr = ent.memo_wr;
	assign upd.memo    = ent.memo;
	assign upd.l       = fwd ? ent.l : lb_ext + ent.l;
	assign upd.r       = fwd ? ent.r : rb_ext + ent.r;

endmodule

// ----- rtl/lfs_ctrl.sv -----
// Tracking state: mode, edge memo, blank counter, stop latch, done and card flags and raw speeds.
// Computes the result for one request; depends on lfs_pkg and lfs_steer.
module lfs_ctrl import lfs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic [1:0]             cmd,
	input  logic [7:0]             g,
	input  logic signed [SpdW-1:0] lbase,
	input  logic signed [SpdW-1:0] rbase,
	output res_t                   res
);

	logic [1:0]             mode_q, mode_n;
	logic [1:0]             memo_q, memo_n;
	logic [CntW-1:0]        cnt_q, cnt_n, cnt_inc, limit;
	logic                   stop_q, stop_n;
	logic signed [RawW-1:0] lraw_q, lraw_n, rraw_q, rraw_n;
	logic                   done_q, done_n;
	logic                   card_q, card_n;
	logic                   active, fwd, blank;
	steer_upd_t             upd;

	assign fwd     = (mode_q == MODE_FWD);
	assign active  = fwd || (mode_q == MODE_REV);
	assign blank   = (g == PAT_ALL_BLACK) || (g == PAT_ALL_WHITE);
	assign cnt_inc = cnt_q + 1'b1;
	assign limit   = fwd ? FWD_BLANK_LIMIT : REV_BLANK_LIMIT;

	lfs_steer u_steer (
		.g     (g),
		.fwd   (fwd),
		.memo  (memo_q),
		.lbase (lbase),
		.rbase (rbase),
		.upd   (upd)
	);

	always_comb begin
		mode_n = mode_q;
		memo_n = memo_q;
		cnt_n  = cnt_q;
		stop_n = stop_q;
		lraw_n = lraw_q;
		rraw_n = rraw_q;
		done_n = done_q;
		card_n = card_q;
		res    = '0;
		unique case (cmd)
			CMD_FWD, CMD_REV: begin
				mode_n = cmd;
				stop_n = 1'b0;
				done_n = 1'b0;
				card_n = 1'b0;
			end
			CMD_CANCEL: begin
				mode_n = MODE_IDLE;
				done_n = 1'b0;
			end
			CMD_SAMPLE: begin
				if (active) begin
					res.mval = 1'b1;
					if (blank) begin
						cnt_n = cnt_inc;
						if (cnt_inc == limit) begin
							cnt_n  = '0;
							stop_n = 1'b1;
						end
						if (fwd && stop_n) begin
							// halt: zero speeds, unclamped
							mode_n = MODE_IDLE;
							done_n = 1'b1;
							if (g == PAT_ALL_WHITE)
								card_n = 1'b1;
						end else begin
							res.left  = clamp_speed(lraw_q);
							res.right = clamp_speed(rraw_q);
						end
					end else begin
						done_n = 1'b0;
						if (upd.take) begin
							lraw_n = upd.l;
							rraw_n = upd.r;
							if (upd.memo_wr)
								memo_n = upd.memo;
						end
						res.left  = clamp_speed(lraw_n);
						res.right = clamp_speed(rraw_n);
					end
				end
			end
		endcase
		res.done = done_n;
		res.card = card_n;
		res.mode = mode_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			memo_q <= MEMO_NONE;
			cnt_q  <= '0;
			stop_q <= 1'b0;
			lraw_q <= '0;
			rraw_q <= '0;
			done_q <= 1'b0;
			card_q <= 1'b0;
		end else if (adv) begin
			mode_q <= mode_n;
			memo_q <= memo_n;
			cnt_q  <= cnt_n;
			stop_q <= stop_n;
			lraw_q <= lraw_n;
			rraw_q <= rraw_n;
			done_q <= done_n;
			card_q <= card_n;
		end
	end

endmodule

// ----- rtl/line_follow_steering_core.sv -----
// Top level of the line-follow steering core: input register, control, result register.
// Depends on lfs_pkg and lfs_ctrl.
//
// Usage:
//   Slave stream: s_tuser carries the command (sample, start forward, start
//   reverse, cancel), s_tdata the eight sensor bits (0 = line seen).
//   Master stream: one result per request; m_tdata packs the two
//   clamped wheel speeds plus done, card and mode status, m_tuser = motor_valid.
//   Config port: cfg_we/cfg_index/cfg_wdata write the reverse base speeds;
//   write only while no request is in flight.
// Path: a request accepted into the input register has its result in m_tdata once the result register takes it.
// Throughput: one request per cycle while the result is not stalled; the tracking state update sits in a single
//   combinational pass between the input register and the result register.
// Reset: all tracking state, base speeds and the valid flags of both stream stages clear; mode idle.
// Stall: if m_tready stays low the result holds, the input stage holds one more
//   request, and s_tready drops until the result is taken.
module line_follow_steering_core import lfs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] sensor_bits
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] left_speed, [15:8] right_speed, [16] track_done,
	                               // [17] card_seen, [19:18] tracking_mode, [23:20] zero
	output logic        m_tuser,   // [0] motor_valid
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_wdata
);

	logic                   valid_s1;
	logic [1:0]             cmd_s1;
	logic [7:0]             sensor_s1;
	logic                   adv;
	logic                   out_valid_q;
	res_t                   res;
	res_t                   res_q;
	logic signed [SpdW-1:0] lbase_q;
	logic signed [SpdW-1:0] rbase_q;

	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lbase_q <= '0;
			rbase_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LEFT_BASE:  lbase_q <= cfg_wdata;
				REG_RIGHT_BASE: rbase_q <= cfg_wdata;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1    <= s_tuser;
			sensor_s1 <= s_tdata;
		end
	end

	lfs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.cmd    (cmd_s1),
		.g      (sensor_s1),
		.lbase  (lbase_q),
		.rbase  (rbase_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, res_q.mode, res_q.card, res_q.done, res_q.right, res_q.left};
	assign m_tuser  = res_q.mval;

	// input stage only blocks when it is full behind a stalled result
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && out_valid_q && !m_tready))
		else $error("s_tready low without a stalled result");

	// no motor command means both speed fields are zero
	a_idle_speed: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[15:0] == 16'd0))
		else $error("speeds nonzero without motor_valid");

	// a motor command comes from active tracking or from the forward halt
	a_cmd_source: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> ((m_tdata[19:18] != MODE_IDLE) || m_tdata[16]))
		else $error("motor command while idle");

	// a held result does not change while the receiver stalls
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> ($stable(res_q) && out_valid_q))
		else $error("result changed under stall");

endmodule

// ----- bench/line_follow_steering_checker.sv -----
// Result checker for line_follow_steering_core: snoops the request, result and config ports,
// predicts every result of the steering core and compares it field by field.
// Depends on lfs_pkg for the command, mode, memo and register codes and the result layout.
module line_follow_steering_checker import lfs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] sensor_bits
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // [7:0] left_speed, [15:8] right_speed, [16] track_done,
	                               // [17] card_seen, [19:18] tracking_mode
	input  logic        m_tuser,   // [0] motor_valid
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_wdata,
	output int          mismatch_count,
	output int          pending
);

	logic signed [7:0] base_left, base_right;
	logic [1:0]        trk_mode, edge_side;
	logic [5:0]        blank_cnt;
	logic              stop_hold, done_flag, card_flag;
	logic signed [9:0] left_raw_s, right_raw_s;

	res_t wheel_cmd_q[$];
	res_t want_res, got_res;

	function automatic logic signed [7:0] limit_wheel(input logic signed [9:0] s);
		int v;
		v = int'(s);
		if (v >= 0)
			v = (v > 100) ? 100 : ((v < 5) ? 5 : v);
		else
			v = (v < -100) ? -100 : ((v > -5) ? -5 : v);
		return v[7:0];
	endfunction

	function automatic void set_raw(input int l, input int r, input logic [1:0] memo);
		left_raw_s  = l[9:0];
		right_raw_s = r[9:0];
		edge_side   = memo;
	endfunction

	// forward uses fixed speeds, reverse adds offsets to the base speeds
	function automatic void steer(input logic [7:0] g, input logic fwd);
		int lb, rb;
		lb = int'(base_left);
		rb = int'(base_right);
		if (g == 8'hE7) begin
			left_raw_s  = fwd ? 10'sd70 : lb[9:0];
			right_raw_s = fwd ? 10'sd95 : rb[9:0];
		end
		if (edge_side != MEMO_LEFT) begin
			case (g)
				8'hF7: set_raw(fwd ? 95 : lb, fwd ? -30 : rb, MEMO_NONE);
				8'hF3, 8'hFB, 8'hF1: set_raw(fwd ? 95 : lb + 155, fwd ? -70 : rb - 5, MEMO_NONE);
				8'hF9, 8'hFD, 8'hF8: set_raw(fwd ? 90 : lb + 160, fwd ? -80 : rb - 10, MEMO_NONE);
				8'hFC: set_raw(fwd ? 90 : lb + 165, fwd ? -90 : rb - 15, MEMO_NONE);
				8'hFE: set_raw(fwd ? 95 : lb + 170, fwd ? -100 : rb - 20, MEMO_RIGHT);
				default: ;
			endcase
		end
		if (edge_side != MEMO_RIGHT) begin
			case (g)
				8'hEF: set_raw(fwd ? -20 : lb, fwd ? 100 : rb, MEMO_NONE);
				8'hCF, 8'hDF, 8'h8F: set_raw(fwd ? -70 : lb, fwd ? 95 : rb + 140, MEMO_NONE);
				8'h9F, 8'h1F: set_raw(fwd ? -80 : lb - 5, fwd ? 95 : rb + 145, MEMO_NONE);
				8'hBF: set_raw(fwd ? -80 : lb - 10, fwd ? 95 : rb + 150, MEMO_NONE);
				8'h3F: set_raw(fwd ? -90 : lb - 10, fwd ? 95 : rb + 150, MEMO_NONE);
				8'h7F: set_raw(fwd ? -100 : lb - 15, fwd ? 95 : rb + 155, MEMO_LEFT);
				default: ;
			endcase
		end
	endfunction

	function automatic res_t steer_response(input logic [1:0] cmd, input logic [7:0] g);
		res_t r;
		logic fwd;
		r = '0;
		case (cmd)
			CMD_FWD, CMD_REV: begin
				trk_mode  = (cmd == CMD_FWD) ? MODE_FWD : MODE_REV;
				stop_hold = 1'b0;
				done_flag = 1'b0;
				card_flag = 1'b0;
			end
			CMD_CANCEL: begin
				trk_mode  = MODE_IDLE;
				done_flag = 1'b0;
			end
			default: begin
				if (trk_mode == MODE_FWD || trk_mode == MODE_REV) begin
					fwd    = (trk_mode == MODE_FWD);
					r.mval = 1'b1;
					if (g == PAT_ALL_BLACK || g == PAT_ALL_WHITE) begin
						blank_cnt = blank_cnt + 6'd1;
						if (blank_cnt == (fwd ? FWD_BLANK_LIMIT : REV_BLANK_LIMIT)) begin
							blank_cnt = '0;
							stop_hold = 1'b1;
						end
						if (fwd && stop_hold) begin
							trk_mode  = MODE_IDLE;
							done_flag = 1'b1;
							if (g == PAT_ALL_WHITE)
								card_flag = 1'b1;
						end else begin
							r.left  = limit_wheel(left_raw_s);
							r.right = limit_wheel(right_raw_s);
						end
					end else begin
						done_flag = 1'b0;
						steer(g, fwd);
						r.left  = limit_wheel(left_raw_s);
						r.right = limit_wheel(right_raw_s);
					end
				end
			end
		endcase
		r.done = done_flag;
		r.card = card_flag;
		r.mode = trk_mode;
		return r;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	initial mismatch_count = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			base_left   = '0;
			base_right  = '0;
			trk_mode    = MODE_IDLE;
			edge_side   = MEMO_NONE;
			blank_cnt   = '0;
			stop_hold   = 1'b0;
			done_flag   = 1'b0;
			card_flag   = 1'b0;
			left_raw_s  = '0;
			right_raw_s = '0;
			wheel_cmd_q.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_LEFT_BASE)
					base_left = cfg_wdata;
				else
					base_right = cfg_wdata;
			end
			if (m_tvalid && m_tready) begin
				got_res.left  = m_tdata[7:0];
				got_res.right = m_tdata[15:8];
				got_res.done  = m_tdata[16];
				got_res.card  = m_tdata[17];
				got_res.mode  = m_tdata[19:18];
				got_res.mval  = m_tuser;
				if (wheel_cmd_q.size() == 0) begin
					$error("result with no request outstanding");
					mismatch_count++;
				end else begin
					want_res = wheel_cmd_q.pop_front();
					check_field("left_speed", int'(want_res.left), int'(got_res.left));
					check_field("right_speed", int'(want_res.right), int'(got_res.right));
					check_field("motor_valid", int'(want_res.mval), int'(got_res.mval));
					check_field("track_done", int'(want_res.done), int'(got_res.done));
					check_field("card_seen", int'(want_res.card), int'(got_res.card));
					check_field("tracking_mode", int'(want_res.mode), int'(got_res.mode));
				end
			end
			if (s_tvalid && s_tready)
				wheel_cmd_q.push_back(steer_response(s_tuser, s_tdata));
			pending <= wheel_cmd_q.size();
		end
	end

endmodule

// ----- bench/line_follow_steering_core_test.sv -----
// Top of the line_follow_steering_core bench: clock, reset, request and config stimulus,
// result back-pressure and the final verdict. Depends on lfs_pkg, the core and
// line_follow_steering_checker, which predicts and compares every result.
module line_follow_steering_core_test import lfs_pkg::*; ();

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid, s_tready;
	logic [7:0]  s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid, m_tready;
	logic [23:0] m_tdata;
	logic        m_tuser;
	logic        cfg_we, cfg_index;
	logic [7:0]  cfg_wdata;
	int          mismatch_count, pending;
	int          idle_pct = 0;
	int          stall_pct = 0;

	line_follow_steering_core uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	line_follow_steering_checker wheel_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.mismatch_count(mismatch_count), .pending(pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic logic [7:0] steer_pattern(input int idx);
		case (idx)
			0: return 8'hE7;   1: return 8'hF7;   2: return 8'hF3;   3: return 8'hFB;
			4: return 8'hF1;   5: return 8'hF9;   6: return 8'hFD;   7: return 8'hF8;
			8: return 8'hFC;   9: return 8'hFE;   10: return 8'hEF;  11: return 8'hCF;
			12: return 8'hDF;  13: return 8'h8F;  14: return 8'h9F;  15: return 8'hBF;
			16: return 8'h1F;  17: return 8'h3F;
			default: return 8'h7F;
		endcase
	endfunction

	// blank bursts push the reverse blank counter up to its stop threshold
	function automatic logic [7:0] pick_bits(input logic burst);
		int r;
		r = $urandom_range(99);
		if (r < (burst ? 85 : 15))
			return $urandom_range(1) ? PAT_ALL_WHITE : PAT_ALL_BLACK;
		if (r < 75)
			return steer_pattern($urandom_range(18));
		return 8'($urandom_range(255));
	endfunction

	task automatic send_req(input logic [1:0] cmd, input logic [7:0] bits);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= bits;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic set_bases(input logic [7:0] l, input logic [7:0] r);
		cfg_we    <= 1'b1;
		cfg_index <= REG_LEFT_BASE;
		cfg_wdata <= l;
		@(posedge clk);
		cfg_index <= REG_RIGHT_BASE;
		cfg_wdata <= r;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int        useful, len, r, phase;
		logic      burst, active;
		logic [1:0] start_cmd;

		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= CMD_SAMPLE;
		cfg_we    <= 1'b0;
		cfg_index <= REG_LEFT_BASE;
		cfg_wdata <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: idle sample, every steering family, memo blocking, stop with card
		set_bases(-8'sd100, 8'sd100);
		send_req(CMD_SAMPLE, 8'hE7);
		send_req(CMD_FWD, 8'h00);
		send_req(CMD_SAMPLE, 8'hE7);
		send_req(CMD_SAMPLE, 8'hF7);
		send_req(CMD_SAMPLE, 8'hF3);
		send_req(CMD_SAMPLE, 8'hF9);
		send_req(CMD_SAMPLE, 8'hFC);
		send_req(CMD_SAMPLE, 8'hFE);
		send_req(CMD_SAMPLE, 8'h7F);
		send_req(CMD_SAMPLE, 8'h5A);
		send_req(CMD_SAMPLE, 8'hF7);
		send_req(CMD_SAMPLE, 8'h7F);
		send_req(CMD_SAMPLE, 8'hFE);
		send_req(CMD_SAMPLE, 8'h3F);
		send_req(CMD_CANCEL, 8'hFF);
		send_req(CMD_REV, 8'h00);
		send_req(CMD_SAMPLE, 8'hFE);
		send_req(CMD_SAMPLE, 8'hEF);
		send_req(CMD_SAMPLE, 8'hF7);
		send_req(CMD_SAMPLE, 8'h7F);
		send_req(CMD_SAMPLE, 8'hBF);
		send_req(CMD_SAMPLE, 8'h00);
		send_req(CMD_FWD, 8'h00);
		repeat (10) send_req(CMD_SAMPLE, PAT_ALL_WHITE);
		send_req(CMD_CANCEL, 8'h00);

		for (phase = 0; phase < 4; phase++) begin
			wait_drained();
			case (phase)
				0: begin
					idle_pct = 0;  stall_pct = 0;
					set_bases(8'sd100, -8'sd100);
				end
				1: begin
					idle_pct = 88; stall_pct = 0;
					set_bases(8'h80, 8'h7F);
				end
				2: begin
					idle_pct = 0;  stall_pct = 88;
					set_bases(8'($urandom_range(200) - 100), 8'($urandom_range(200) - 100));
				end
				default: begin
					idle_pct = 37; stall_pct = 37;
					set_bases(8'($urandom_range(255)), 8'($urandom_range(255)));
				end
			endcase
			useful = 0;
			active = 1'b0;
			while (useful < 350) begin
				r = $urandom_range(99);
				start_cmd = (r < 48) ? CMD_FWD : CMD_REV;
				if (r < 95) begin
					send_req(start_cmd, 8'($urandom_range(255)));
					active = 1'b1;
					useful++;
				end
				burst = (start_cmd == CMD_REV) && ($urandom_range(3) == 0);
				len = burst ? $urandom_range(20, 70) : $urandom_range(3, 40);
				repeat (len) begin
					r = $urandom_range(99);
					if (r < 2) begin
						send_req(CMD_CANCEL, 8'($urandom_range(255)));
						active = 1'b0;
						useful++;
					end else if (r < 4) begin
						send_req((r < 3) ? CMD_FWD : CMD_REV, 8'($urandom_range(255)));
						active = 1'b1;
						useful++;
					end else begin
						send_req(CMD_SAMPLE, pick_bits(burst));
						if (active)
							useful++;
					end
					if ($urandom_range(299) == 0)
						wait_drained();
				end
			end
		end

		wait_drained();
		repeat (5) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
